/* hdl/pea_pkg.sv */
// Shared constants, codes and types of the page extent allocator.
package pea_pkg;

    localparam int PAGE_BITS   = 40;
    localparam int LEN_BITS    = PAGE_BITS + 1;
    localparam int ENTRY_BITS  = PAGE_BITS + LEN_BITS;
    localparam int MAX_EXTENTS_DEFAULT = 64;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ALU_ADD    = 2'd0,
        ALU_SUB    = 2'd1,
        ALU_SATADD = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } alu_flags_t;

endpackage

/* hdl/pea_if.sv */
// Request and response channel interfaces of the page extent allocator.
interface pea_req_if import pea_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [LEN_BITS-1:0]  pages;
    logic [PAGE_BITS-1:0] limit_page;
    logic [PAGE_BITS-1:0] start_page;

    modport source (output valid, kind, pages, limit_page, start_page, input ready);
    modport sink   (input valid, kind, pages, limit_page, start_page, output ready);
endinterface

interface pea_rsp_if import pea_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [PAGE_BITS-1:0] alloc_page;

    modport source (output valid, status, alloc_page, input ready);
    modport sink   (input valid, status, alloc_page, output ready);
endinterface

/* hdl/pea_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pea_alu.sv */
// Shared add, subtract and saturating-add unit with compare flags.
module pea_alu import pea_pkg::*; (
    input  alu_op_t             op,
    input  logic [LEN_BITS-1:0] a,
    input  logic [LEN_BITS-1:0] b,
    output logic [LEN_BITS-1:0] res,
    output alu_flags_t          flags
);

    logic [LEN_BITS:0] sum;
    logic [LEN_BITS:0] diff;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = {1'b0, a} - {1'b0, b};

    always_comb
    begin
        case (op)
            ALU_ADD:    res = sum[LEN_BITS-1:0];
            ALU_SUB:    res = diff[LEN_BITS-1:0];
            ALU_SATADD: res = sum[LEN_BITS] ? {LEN_BITS{1'b1}} : sum[LEN_BITS-1:0];
            default:    res = sum[LEN_BITS-1:0];
        endcase
        flags.lt = diff[LEN_BITS];
        flags.eq = (a == b);
    end

endmodule

/* hdl/page_extent_allocator.sv */
// Top level of the page extent allocator: sequencer, extent table and shared unit.
// One request is handled at a time and the request channel is not ready until its
// response has been formed. An allocate reads the table entries from the top down,
// testing each on length and on the page limit, then carves the extent and moves
// entries when the extent splits or empties. A free reads the entries below the
// freed start, tests and merges neighbors, and moves entries on insertion or
// removal. These steps run one after another because of the single read port of
// the extent table and the one shared adder. A finished response waits in an
// output register while the next request is taken.
module page_extent_allocator import pea_pkg::*; #(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    pea_req_if.sink   req,
    pea_rsp_if.source rsp
);

    localparam int AW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [25:0] {
        S_IDLE   = 26'd1 << 0,
        S_LIMP   = 26'd1 << 1,
        S_A_RD   = 26'd1 << 2,
        S_A_LD   = 26'd1 << 3,
        S_A_SUB  = 26'd1 << 4,
        S_A_CMP  = 26'd1 << 5,
        S_A_TOP  = 26'd1 << 6,
        S_A_BOT  = 26'd1 << 7,
        S_A_PG   = 26'd1 << 8,
        S_A_NS   = 26'd1 << 9,
        S_A_NL   = 26'd1 << 10,
        S_A_WB   = 26'd1 << 11,
        S_F_RD   = 26'd1 << 12,
        S_F_LD   = 26'd1 << 13,
        S_F_BK   = 26'd1 << 14,
        S_F_BK2  = 26'd1 << 15,
        S_F_FW   = 26'd1 << 16,
        S_F_FW2  = 26'd1 << 17,
        S_F_DEC  = 26'd1 << 18,
        S_F_M2   = 26'd1 << 19,
        S_WR     = 26'd1 << 20,
        S_INS_RD = 26'd1 << 21,
        S_INS_WR = 26'd1 << 22,
        S_REM_RD = 26'd1 << 23,
        S_REM_WR = 26'd1 << 24,
        S_DONE   = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next;

    logic                 kind_reg, kind_next;
    logic [LEN_BITS-1:0]  cnt_reg, cnt_next;
    logic [PAGE_BITS-1:0] lim_reg, lim_next;
    logic [PAGE_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0]  limp_reg, limp_next;
    logic [PAGE_BITS-1:0] s_reg, s_next;
    logic [LEN_BITS-1:0]  len_reg, len_next;
    logic [PAGE_BITS-1:0] nx_s_reg, nx_s_next;
    logic [LEN_BITS-1:0]  nx_len_reg, nx_len_next;
    logic [LEN_BITS-1:0]  tmp_reg, tmp_next;
    logic [LEN_BITS-1:0]  top_reg, top_next;
    logic [LEN_BITS-1:0]  bot_reg, bot_next;
    logic                 split_reg, split_next;
    logic                 botnz_reg, botnz_next;
    logic                 back_reg, back_next;
    logic                 fwd_reg, fwd_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [1:0]           status_reg, status_next;
    logic [PAGE_BITS-1:0] new_s_reg, new_s_next;
    logic [LEN_BITS-1:0]  new_len_reg, new_len_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        used_reg, used_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [PAGE_BITS-1:0] out_page_reg, out_page_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [PAGE_BITS-1:0]  rd_s;
    logic [LEN_BITS-1:0]   rd_len;

    alu_op_t             alu_op;
    logic [LEN_BITS-1:0] alu_a;
    logic [LEN_BITS-1:0] alu_b;
    logic [LEN_BITS-1:0] alu_res;
    alu_flags_t          alu_flags;

    logic          used_full;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] pos_dec;

    pea_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_EXTENTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pea_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    assign rd_s   = ram_rdata[ENTRY_BITS-1 -: PAGE_BITS];
    assign rd_len = ram_rdata[LEN_BITS-1:0];

    assign used_full = (used_reg >= CW'(MAX_EXTENTS));
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign pos_dec   = pos_reg - CW'(1);

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.alloc_page = out_page_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cnt_next        = cnt_reg;
        lim_next        = lim_reg;
        start_next      = start_reg;
        limp_next       = limp_reg;
        s_next          = s_reg;
        len_next        = len_reg;
        nx_s_next       = nx_s_reg;
        nx_len_next     = nx_len_reg;
        tmp_next        = tmp_reg;
        top_next        = top_reg;
        bot_next        = bot_reg;
        split_next      = split_reg;
        botnz_next      = botnz_reg;
        back_next       = back_reg;
        fwd_next        = fwd_reg;
        page_next       = page_reg;
        status_next     = status_reg;
        new_s_next      = new_s_reg;
        new_len_next    = new_len_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        used_next       = used_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = {new_s_reg, new_len_reg};
        ram_raddr = idx_reg[AW-1:0];
        alu_op    = ALU_SUB;
        alu_a     = '0;
        alu_b     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.kind;
                    cnt_next    = req.pages;
                    lim_next    = req.limit_page;
                    start_next  = req.start_page;
                    page_next   = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    pos_next    = '0;
                    if (req.kind == KIND_FREE)
                    begin
                        if (req.pages == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (used_reg == '0)
                        begin
                            state_next = S_F_BK;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                    else if (req.pages == '0)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LIMP;
                    end
                end
            end
            S_LIMP:
            begin
                alu_op    = ALU_ADD;
                alu_a     = LEN_BITS'(lim_reg);
                alu_b     = LEN_BITS'(1);
                limp_next = alu_res;
                if (used_reg == '0)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = used_reg - CW'(1);
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_LD;
            end
            S_A_LD, S_A_SUB, S_A_CMP:
            begin
                alu_op = ALU_SUB;
                if (state_reg == S_A_LD)
                begin
                    alu_a    = rd_len;
                    alu_b    = cnt_reg;
                    s_next   = rd_s;
                    len_next = rd_len;
                end
                else if (state_reg == S_A_SUB)
                begin
                    alu_a    = limp_reg;
                    alu_b    = LEN_BITS'(s_reg);
                    tmp_next = alu_res;
                end
                else
                begin
                    alu_a = tmp_reg;
                    alu_b = cnt_reg;
                end
                if (alu_flags.lt)
                begin
                    if (idx_reg == '0)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_dec;
                        state_next = S_A_RD;
                    end
                end
                else if (state_reg == S_A_LD)
                begin
                    state_next = S_A_SUB;
                end
                else if (state_reg == S_A_SUB)
                begin
                    state_next = S_A_CMP;
                end
                else
                begin
                    state_next = S_A_TOP;
                end
            end
            S_A_TOP:
            begin
                alu_op     = ALU_SUB;
                alu_a      = tmp_reg;
                alu_b      = len_reg;
                split_next = alu_flags.lt;
                top_next   = alu_flags.lt ? tmp_reg : len_reg;
                state_next = S_A_BOT;
            end
            S_A_BOT:
            begin
                alu_op     = ALU_SUB;
                alu_a      = top_reg;
                alu_b      = cnt_reg;
                bot_next   = alu_res;
                botnz_next = !alu_flags.eq;
                if (split_reg && !alu_flags.eq && used_full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_A_PG;
                end
            end
            S_A_PG:
            begin
                alu_op     = ALU_ADD;
                alu_a      = LEN_BITS'(s_reg);
                alu_b      = bot_reg;
                page_next  = alu_res[PAGE_BITS-1:0];
                state_next = S_A_NS;
            end
            S_A_NS:
            begin
                alu_op     = ALU_ADD;
                alu_a      = LEN_BITS'(s_reg);
                alu_b      = top_reg;
                new_s_next = alu_res[PAGE_BITS-1:0];
                state_next = S_A_NL;
            end
            S_A_NL:
            begin
                alu_op       = ALU_SUB;
                alu_a        = len_reg;
                alu_b        = top_reg;
                new_len_next = alu_res;
                if (split_reg && botnz_reg)
                begin
                    state_next = S_A_WB;
                end
                else if (split_reg)
                begin
                    state_next = S_WR;
                end
                else if (botnz_reg)
                begin
                    new_s_next   = s_reg;
                    new_len_next = bot_reg;
                    state_next   = S_WR;
                end
                else
                begin
                    state_next = S_REM_RD;
                end
            end
            S_A_WB:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {s_reg, bot_reg};
                pos_next   = idx_inc;
                idx_next   = used_reg;
                state_next = S_INS_RD;
            end
            S_F_RD:
            begin
                state_next = S_F_LD;
            end
            S_F_LD:
            begin
                alu_op = ALU_SUB;
                alu_a  = LEN_BITS'(start_reg);
                alu_b  = LEN_BITS'(rd_s);
                if (alu_flags.lt)
                begin
                    pos_next    = idx_reg;
                    nx_s_next   = rd_s;
                    nx_len_next = rd_len;
                    state_next  = S_F_BK;
                end
                else
                begin
                    s_next   = rd_s;
                    len_next = rd_len;
                    if (idx_inc == used_reg)
                    begin
                        pos_next   = used_reg;
                        state_next = S_F_BK;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_F_RD;
                    end
                end
            end
            S_F_BK:
            begin
                alu_op    = ALU_SUB;
                alu_a     = LEN_BITS'(start_reg);
                alu_b     = LEN_BITS'(s_reg);
                tmp_next  = alu_res;
                back_next = 1'b0;
                if (pos_reg != '0)
                begin
                    state_next = S_F_BK2;
                end
                else
                begin
                    state_next = S_F_FW;
                end
            end
            S_F_BK2:
            begin
                alu_a      = tmp_reg;
                alu_b      = len_reg;
                back_next  = alu_flags.eq;
                state_next = S_F_FW;
            end
            S_F_FW:
            begin
                alu_op   = ALU_SUB;
                alu_a    = LEN_BITS'(nx_s_reg);
                alu_b    = LEN_BITS'(start_reg);
                tmp_next = alu_res;
                fwd_next = 1'b0;
                if (pos_reg < used_reg)
                begin
                    state_next = S_F_FW2;
                end
                else
                begin
                    state_next = S_F_DEC;
                end
            end
            S_F_FW2:
            begin
                alu_a      = tmp_reg;
                alu_b      = cnt_reg;
                fwd_next   = alu_flags.eq;
                state_next = S_F_DEC;
            end
            S_F_DEC:
            begin
                alu_op = ALU_SATADD;
                alu_b  = cnt_reg;
                if (back_reg && fwd_reg)
                begin
                    alu_a      = len_reg;
                    tmp_next   = alu_res;
                    state_next = S_F_M2;
                end
                else if (back_reg)
                begin
                    alu_a        = len_reg;
                    new_s_next   = s_reg;
                    new_len_next = alu_res;
                    idx_next     = pos_dec;
                    state_next   = S_WR;
                end
                else if (fwd_reg)
                begin
                    alu_a        = nx_len_reg;
                    new_s_next   = start_reg;
                    new_len_next = alu_res;
                    idx_next     = pos_reg;
                    state_next   = S_WR;
                end
                else if (used_full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    new_s_next   = start_reg;
                    new_len_next = cnt_reg;
                    idx_next     = used_reg;
                    state_next   = S_INS_RD;
                end
            end
            S_F_M2:
            begin
                alu_op     = ALU_SATADD;
                alu_a      = tmp_reg;
                alu_b      = nx_len_reg;
                ram_we     = 1'b1;
                ram_waddr  = pos_dec[AW-1:0];
                ram_wdata  = {s_reg, alu_res};
                idx_next   = pos_reg;
                state_next = S_REM_RD;
            end
            S_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ram_we     = 1'b1;
                    used_next  = used_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end
            S_REM_RD:
            begin
                if (idx_inc == used_reg)
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_inc[AW-1:0];
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = S_REM_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_page_next   = (status_reg == ST_OK) ? page_reg : '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        cnt_reg        <= cnt_next;
        lim_reg        <= lim_next;
        start_reg      <= start_next;
        limp_reg       <= limp_next;
        s_reg          <= s_next;
        len_reg        <= len_next;
        nx_s_reg       <= nx_s_next;
        nx_len_reg     <= nx_len_next;
        tmp_reg        <= tmp_next;
        top_reg        <= top_next;
        bot_reg        <= bot_next;
        split_reg      <= split_next;
        botnz_reg      <= botnz_next;
        back_reg       <= back_next;
        fwd_reg        <= fwd_next;
        page_reg       <= page_next;
        status_reg     <= status_next;
        new_s_reg      <= new_s_next;
        new_len_reg    <= new_len_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
    end

endmodule

/* hdl/pea_chk.sv */
// Port-level checker of the page extent allocator and its bind statement.
module pea_chk import pea_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [1:0]           rsp_status,
    input logic [PAGE_BITS-1:0] rsp_alloc_page
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
            && $stable(rsp_alloc_page)))
        else $error("response changed while stalled");

    a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != ST_OK) |-> (rsp_alloc_page == '0))
        else $error("failed request returned a nonzero page");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request channel stayed ready after an accept");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared without a request in progress");

endmodule

bind page_extent_allocator pea_chk u_pea_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_alloc_page (rsp.alloc_page)
);

/* bench/tb_top.sv */
// Testbench of the page extent allocator: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import pea_pkg::*;

    localparam int          TABLE_DEPTH = 64;
    localparam logic [63:0] PAGE_MASK   = (64'd1 << PAGE_BITS) - 64'd1;
    localparam logic [63:0] LEN_MASK    = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [63:0] TOP_PAGE    = PAGE_MASK;
    localparam logic [63:0] MAX_COUNT   = 64'd1 << PAGE_BITS;
    localparam int          CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]           status;
        logic [PAGE_BITS-1:0] page;
    } grant_t;

    typedef struct {
        logic [63:0] first;
        logic [63:0] count;
    } chunk_t;

    class extent_scoreboard;
        logic [63:0] ext_start [TABLE_DEPTH];
        logic [63:0] ext_len [TABLE_DEPTH];
        int          used;
        grant_t      grants_due[$];
        chunk_t      granted[$];
        int          mismatches;
        int          checked;
        int          n_full;
        int          n_nofit;
        int          n_alloc_ok;

        function new();
            used = 0;
            mismatches = 0;
            checked = 0;
            n_full = 0;
            n_nofit = 0;
            n_alloc_ok = 0;
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            return (s > LEN_MASK) ? LEN_MASK : s;
        endfunction

        function void drop_entry(int i);
            for (int k = i; k + 1 < used; k++)
            begin
                ext_start[k] = ext_start[k + 1];
                ext_len[k] = ext_len[k + 1];
            end
            used--;
        endfunction

        function void add_entry(int i, logic [63:0] s, logic [63:0] l);
            for (int k = used; k > i; k--)
            begin
                ext_start[k] = ext_start[k - 1];
                ext_len[k] = ext_len[k - 1];
            end
            ext_start[i] = s & PAGE_MASK;
            ext_len[i] = l & LEN_MASK;
            used++;
        endfunction

        function logic [1:0] carve(logic [63:0] c, logic [63:0] lim, output logic [63:0] pg);
            logic [63:0] s;
            logic [63:0] len;
            logic [63:0] top;
            logic [63:0] bot;
            pg = '0;
            if (c == 0)
                return ST_NOFIT;
            for (int n = used; n > 0; n--)
            begin
                s = ext_start[n - 1];
                len = ext_len[n - 1];
                if (len < c || s + c - 1 > lim)
                    continue;
                top = lim + 1 - s;
                if (top > len)
                    top = len;
                bot = top - c;
                if (top < len && bot > 0 && used >= TABLE_DEPTH)
                    return ST_FULL;
                if (top < len)
                begin
                    if (bot > 0)
                    begin
                        ext_len[n - 1] = bot;
                        add_entry(n, s + top, len - top);
                    end
                    else
                    begin
                        ext_start[n - 1] = (s + top) & PAGE_MASK;
                        ext_len[n - 1] = len - top;
                    end
                end
                else if (bot > 0)
                    ext_len[n - 1] = bot;
                else
                    drop_entry(n - 1);
                pg = (s + bot) & PAGE_MASK;
                return ST_OK;
            end
            return ST_NOFIT;
        endfunction

        function logic [1:0] give_back(logic [63:0] s, logic [63:0] c);
            int  i;
            bit  back;
            bit  fwd;
            i = 0;
            if (c == 0)
                return ST_OK;
            while (i < used && !(s < ext_start[i]))
                i++;
            back = i > 0 && (s - ext_start[i - 1]) == ext_len[i - 1];
            fwd = i < used && (ext_start[i] - s) == c;
            if (back && fwd)
            begin
                ext_len[i - 1] = sat_sum(sat_sum(ext_len[i - 1], c), ext_len[i]);
                drop_entry(i);
            end
            else if (back)
                ext_len[i - 1] = sat_sum(ext_len[i - 1], c);
            else if (fwd)
            begin
                ext_start[i] = s;
                ext_len[i] = sat_sum(ext_len[i], c);
            end
            else
            begin
                if (used >= TABLE_DEPTH)
                    return ST_FULL;
                add_entry(i, s, c);
            end
            return ST_OK;
        endfunction

        function void note_request(logic k, logic [63:0] c, logic [63:0] lim, logic [63:0] s);
            grant_t      g;
            logic [63:0] pg;
            chunk_t      ch;
            pg = '0;
            if (k == KIND_ALLOC)
                g.status = carve(c, lim, pg);
            else
                g.status = give_back(s, c);
            if (g.status != ST_OK)
                pg = '0;
            g.page = pg[PAGE_BITS-1:0];
            if (g.status == ST_FULL)
                n_full++;
            if (g.status == ST_NOFIT)
                n_nofit++;
            if (k == KIND_ALLOC && g.status == ST_OK)
            begin
                n_alloc_ok++;
                ch.first = pg;
                ch.count = c;
                granted.push_back(ch);
            end
            grants_due.push_back(g);
        endfunction

        function void check_response(logic [1:0] status, logic [PAGE_BITS-1:0] page);
            grant_t g;
            checked++;
            if (grants_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response status=%0d page=%h", status, page);
                return;
            end
            g = grants_due.pop_front();
            if (status !== g.status || page !== g.page)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d: expected status=%0d page=%h, %s%0d page=%h",
                             checked, g.status, g.page, "got status=", status, page);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idling_on;
    int   cycles;
    int   stall_left;

    extent_scoreboard sb;

    pea_req_if req ();
    pea_rsp_if rsp ();

    page_extent_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ERROR: cycle limit reached with %0d responses outstanding",
                     sb.grants_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_response(rsp.status, rsp.alloc_page);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand_page();
        return {$urandom, $urandom} & PAGE_MASK;
    endfunction

    task automatic send(logic k, logic [63:0] c, logic [63:0] lim, logic [63:0] s);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= k;
        req.pages <= c[LEN_BITS-1:0];
        req.limit_page <= lim[PAGE_BITS-1:0];
        req.start_page <= s[PAGE_BITS-1:0];
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(k, c, lim, s);
    endtask

    task automatic send_random();
        logic [63:0] c;
        logic [63:0] lim;
        int          pick;
        chunk_t      ch;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            c = (pick < 40) ? 64'($urandom_range(1, 16)) : ({$urandom, $urandom} & LEN_MASK);
            if (c[PAGE_BITS] || c == 0)
                c = (c == 0) ? 64'd1 : MAX_COUNT;
            lim = ($urandom_range(0, 2) == 0) ? rand_page() : TOP_PAGE;
            send(KIND_ALLOC, c, lim, rand_page());
        end
        else if (pick < 85 && sb.granted.size() > 0)
        begin
            pick = $urandom_range(0, sb.granted.size() - 1);
            ch = sb.granted[pick];
            sb.granted.delete(pick);
            send(KIND_FREE, ch.count, rand_page(), ch.first);
        end
        else
        begin
            c = ({$urandom, $urandom} & LEN_MASK) >> $urandom_range(0, 40);
            if (c[PAGE_BITS] || c == 0)
                c = (c == 0) ? 64'd1 : MAX_COUNT;
            send(KIND_FREE, c, rand_page(), rand_page());
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        stall_left = 0;
        idling_on = 1'b1;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_ALLOC;
        req.pages = '0;
        req.limit_page = '0;
        req.start_page = '0;
        rsp.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(KIND_ALLOC, 64'd0, TOP_PAGE, 64'd0);
        send(KIND_FREE, 64'd0, 64'd0, 64'd77);
        send(KIND_ALLOC, 64'd1, TOP_PAGE, 64'd0);
        send(KIND_FREE, MAX_COUNT, 64'd0, 64'd0);
        send(KIND_ALLOC, MAX_COUNT, TOP_PAGE, 64'd0);
        send(KIND_FREE, 64'd1, 64'd0, TOP_PAGE);
        send(KIND_FREE, 64'd1, 64'd0, TOP_PAGE - 64'd1);
        send(KIND_FREE, 64'd1, 64'd0, TOP_PAGE - 64'd3);
        send(KIND_FREE, 64'd1, 64'd0, TOP_PAGE - 64'd2);
        send(KIND_ALLOC, 64'd1, TOP_PAGE - 64'd1, 64'd0);
        send(KIND_ALLOC, 64'd2, TOP_PAGE, 64'd0);
        send(KIND_ALLOC, 64'd1, TOP_PAGE - 64'd3, 64'd0);
        send(KIND_FREE, 64'd1, 64'd0, 64'd100);
        send(KIND_FREE, 64'd1, 64'd0, 64'd100);
        send(KIND_ALLOC, 64'd5, 64'd50, 64'd0);
        send(KIND_FREE, 64'd3, 64'd0, 64'd1000);
        for (int k = 1; sb.used < TABLE_DEPTH; k++)
            send(KIND_FREE, 64'd1, 64'd0, 64'd1000 + 64'(8 * k));
        send(KIND_FREE, 64'd1, 64'd0, 64'd5000000);
        send(KIND_ALLOC, 64'd1, 64'd1001, 64'd0);
        send(KIND_FREE, 64'd1 << 20, 64'd0, 64'd1 << 30);

        for (int n = 0; n < 520; n++)
        begin
            if (n == 440)
                idling_on = 1'b0;
            send_random();
        end
        req.valid <= 1'b0;

        while (sb.grants_due.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("Checked %0d responses: %0d grants, %0d without fit, %0d table-full.",
                 sb.checked, sb.n_alloc_ok, sb.n_nofit, sb.n_full);
        if (sb.mismatches == 0 && sb.grants_due.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
